### src/lbmc_pkg.sv
// Shared constants for the D2Q9 BGK collision pipeline.
// Default widths, configuration register indexes and the velocity limit reset value.
// No dependencies.
`default_nettype none
package lbmc_pkg;
	localparam int DATA_WIDTH = 24;
	localparam int FRAC_BITS  = 20;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_RELAX_RATE     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_LIMIT = 1'd1;

	// velocity limit reset: close to one over root three in Q20, rescaled to the fraction width
	localparam longint VLIM_RESET_Q20 = 605305;
endpackage
`default_nettype wire

### src/lbmc_div.sv
// Pipelined restoring divider for one clamped velocity component, one quotient bit a stage.
// Takes a moment and the density, gives the signed velocity clamped to the limit.
// Depends on nothing but its parameters.
`default_nettype none
module lbmc_div #(
	parameter int DATA_WIDTH = 24,
	parameter int FRAC_BITS  = 20
) (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic signed [DATA_WIDTH+3:0]  m,
	input  wire logic signed [DATA_WIDTH-1:0]  rho,
	input  wire logic        [FRAC_BITS:0]     lim,
	output logic signed      [FRAC_BITS+1:0]   vel_s
);
	localparam int DW = DATA_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int MW = DW + 4;
	localparam int QW = F + 2;
	localparam int VW = F + 2;
	localparam int RW = DW + F + 1;

	logic [RW-1:0] r_s    [QW+1];
	logic [QW-1:0] q_s    [QW+1];
	logic [DW-2:0] d_s    [QW+1];
	logic          neg_s  [QW+1];
	logic          zero_s [QW+1];
	logic          sat_s  [QW+1];

	logic          neg;
	logic [MW-1:0] absm;
	logic          nonpos;
	logic          ovf;

	always_comb begin
		neg    = m[MW-1];
		absm   = neg ? MW'(-m) : MW'(m);
		nonpos = (rho <= 0);
		ovf    = absm >= MW'({rho, 2'b00});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0]    <= {absm[DW:0], {F{1'b0}}};
			q_s[0]    <= '0;
			d_s[0]    <= rho[DW-2:0];
			neg_s[0]  <= neg;
			zero_s[0] <= (m == 0);
			sat_s[0]  <= nonpos | ovf;
		end
	end

	for (genvar j = 1; j <= QW; j++) begin : g_step
		localparam int K = QW - j;
		logic [RW:0] trial;
		logic        qbit;
		always_comb begin
			trial = {1'b0, r_s[j-1]} - ({{(RW+2-DW){1'b0}}, d_s[j-1]} << K);
			qbit  = !trial[RW];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[j]    <= qbit ? trial[RW-1:0] : r_s[j-1];
				q_s[j]    <= {q_s[j-1][QW-2:0], qbit};
				d_s[j]    <= d_s[j-1];
				neg_s[j]  <= neg_s[j-1];
				zero_s[j] <= zero_s[j-1];
				sat_s[j]  <= sat_s[j-1];
			end
		end
	end

	logic [QW-1:0] mag;
	always_comb begin
		if (zero_s[QW])
			mag = '0;
		else if (sat_s[QW] || (q_s[QW] > QW'(lim)))
			mag = QW'(lim);
		else
			mag = q_s[QW];
	end

	always_ff @(posedge clk) begin
		if (en)
			vel_s <= neg_s[QW] ? -$signed(VW'(mag)) : $signed(VW'(mag));
	end
endmodule
`default_nettype wire

### src/lbmc_feq.sv
// Equilibrium and relaxation pipeline: squares, equilibrium terms, weighting, relaxation.
// Six register stages, the last one is the output register.
// Depends on nothing but its parameters.
`default_nettype none
module lbmc_feq #(
	parameter int DATA_WIDTH = 24,
	parameter int FRAC_BITS  = 20
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         in_valid,
	input  wire logic signed [DATA_WIDTH-1:0] f [9],
	input  wire logic signed [DATA_WIDTH-1:0] rho,
	input  wire logic signed [FRAC_BITS+1:0]  ux,
	input  wire logic signed [FRAC_BITS+1:0]  uy,
	input  wire logic                         byp,
	input  wire logic        [FRAC_BITS+1:0]  relax,
	output logic                              out_valid,
	output logic signed [DATA_WIDTH-1:0]      out_f [9],
	output logic signed [DATA_WIDTH-1:0]      out_rho,
	output logic signed [FRAC_BITS+1:0]       out_ux,
	output logic signed [FRAC_BITS+1:0]       out_uy
);
	localparam int DW  = DATA_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int VW  = F + 2;
	localparam int CW  = VW + 1;
	localparam int SQW = 2 * CW;
	localparam int C2W = F + 4;
	localparam int U2W = F + 3;
	localparam int IW  = F + 8;
	localparam int TW  = F + 6;
	localparam int PW  = DW + TW;
	localparam int SW  = DW + 7;
	localparam int WW  = F + 1;
	localparam int QPW = SW + WW;
	localparam int EW  = DW + 7;
	localparam int DDW = DW + 8;
	localparam int RPW = DDW + F + 3;
	localparam int OW  = DW + 12;

	localparam longint WR = ((longint'(8) << F) + 9) / 18;
	localparam longint WA = ((longint'(2) << F) + 9) / 18;
	localparam longint WD = ((longint'(2) << F) + 36) / 72;
	localparam logic signed [WW-1:0] W_REST = WW'(WR);
	localparam logic signed [WW-1:0] W_AXIS = WW'(WA);
	localparam logic signed [WW-1:0] W_DIAG = WW'(WD);
	localparam longint HALF = longint'(1) << (F - 1);
	localparam logic signed [SW-1:0] ONE_S = SW'(longint'(1) << F);
	localparam logic signed [OW-1:0] MAX_O = OW'((longint'(1) << (DW - 1)) - 1);
	localparam logic signed [OW-1:0] MIN_O = -MAX_O - OW'(1);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [DW-1:0] f_s1 [9], f_s2 [9], f_s3 [9], f_s4 [9], f_s5 [9];
	logic signed [DW-1:0] rho_s1, rho_s2, rho_s3, rho_s4, rho_s5;
	logic signed [VW-1:0] ux_s1, ux_s2, ux_s3, ux_s4, ux_s5;
	logic signed [VW-1:0] uy_s1, uy_s2, uy_s3, uy_s4, uy_s5;
	logic                 byp_s1, byp_s2, byp_s3, byp_s4, byp_s5;

	logic signed [SQW-1:0] sqx_s1, sqy_s1, sqp_s1, sqm_s1;
	logic signed [TW-1:0]  t_s2 [9];
	logic signed [PW-1:0]  p_s3 [9];
	logic signed [QPW-1:0] q_s4 [9];
	logic signed [RPW-1:0] r_s5 [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			out_valid <= v_s5;
		end
	end

	// squares of the projected velocities
	logic signed [CW-1:0] cp, cm;
	always_comb begin
		cp = CW'(ux) + CW'(uy);
		cm = CW'(ux) - CW'(uy);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s1 <= SQW'(ux) * SQW'(ux);
			sqy_s1 <= SQW'(uy) * SQW'(uy);
			sqp_s1 <= SQW'(cp) * SQW'(cp);
			sqm_s1 <= SQW'(cm) * SQW'(cm);
			f_s1   <= f;
			rho_s1 <= rho;
			ux_s1  <= ux;
			uy_s1  <= uy;
			byp_s1 <= byp;
		end
	end

	// equilibrium polynomial per direction
	logic signed [SQW-1:0] rx, ry, rp, rm;
	logic signed [C2W-1:0] c2x, c2y, c2p, c2m;
	logic signed [U2W-1:0] u2;
	logic signed [CW-1:0]  cu  [9];
	logic signed [C2W-1:0] cu2 [9];
	logic signed [IW-1:0]  inner [9];
	logic signed [TW-1:0]  t   [9];
	always_comb begin
		rx  = sqx_s1 + SQW'(HALF);
		ry  = sqy_s1 + SQW'(HALF);
		rp  = sqp_s1 + SQW'(HALF);
		rm  = sqm_s1 + SQW'(HALF);
		c2x = rx[F+C2W-1:F];
		c2y = ry[F+C2W-1:F];
		c2p = rp[F+C2W-1:F];
		c2m = rm[F+C2W-1:F];
		u2  = U2W'(c2x) + U2W'(c2y);
		cu[0] = '0;
		cu[1] = CW'(ux_s1);
		cu[2] = -CW'(ux_s1);
		cu[3] = CW'(uy_s1);
		cu[4] = -CW'(uy_s1);
		cu[5] = CW'(ux_s1) + CW'(uy_s1);
		cu[6] = -(CW'(ux_s1) + CW'(uy_s1));
		cu[7] = CW'(ux_s1) - CW'(uy_s1);
		cu[8] = CW'(uy_s1) - CW'(ux_s1);
		cu2[0] = '0;
		cu2[1] = c2x;
		cu2[2] = c2x;
		cu2[3] = c2y;
		cu2[4] = c2y;
		cu2[5] = c2p;
		cu2[6] = c2p;
		cu2[7] = c2m;
		cu2[8] = c2m;
		for (int i = 0; i < 9; i++) begin
			inner[i] = (IW'(9) * IW'(cu2[i]) - IW'(3) * IW'(u2) + IW'(1)) >>> 1;
			t[i]     = TW'(IW'(3) * IW'(cu[i]) + inner[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s2   <= t;
			f_s2   <= f_s1;
			rho_s2 <= rho_s1;
			ux_s2  <= ux_s1;
			uy_s2  <= uy_s1;
			byp_s2 <= byp_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++)
				p_s3[i] <= PW'(rho_s2) * PW'(t_s2[i]);
			f_s3   <= f_s2;
			rho_s3 <= rho_s2;
			ux_s3  <= ux_s2;
			uy_s3  <= uy_s2;
			byp_s3 <= byp_s2;
		end
	end

	// weight the shifted equilibrium
	logic signed [PW-1:0]  pr [9];
	logic signed [SW-1:0]  s  [9];
	logic signed [WW-1:0]  wgt [9];
	always_comb begin
		wgt[0] = W_REST;
		for (int i = 1; i < 5; i++)
			wgt[i] = W_AXIS;
		for (int i = 5; i < 9; i++)
			wgt[i] = W_DIAG;
		for (int i = 0; i < 9; i++) begin
			pr[i] = p_s3[i] + PW'(HALF);
			s[i]  = SW'($signed(pr[i][PW-1:F])) + SW'(rho_s3) - ONE_S;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++)
				q_s4[i] <= QPW'(wgt[i]) * QPW'(s[i]);
			f_s4   <= f_s3;
			rho_s4 <= rho_s3;
			ux_s4  <= ux_s3;
			uy_s4  <= uy_s3;
			byp_s4 <= byp_s3;
		end
	end

	// relax toward equilibrium
	logic signed [QPW-1:0] qr [9];
	logic signed [DDW-1:0] dlt [9];
	logic signed [F+2:0]   rate;
	always_comb begin
		rate = $signed({1'b0, relax});
		for (int i = 0; i < 9; i++) begin
			qr[i]  = q_s4[i] + QPW'(HALF);
			dlt[i] = DDW'($signed(qr[i][F+EW-1:F])) - DDW'(f_s4[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++)
				r_s5[i] <= RPW'(rate) * RPW'(dlt[i]);
			f_s5   <= f_s4;
			rho_s5 <= rho_s4;
			ux_s5  <= ux_s4;
			uy_s5  <= uy_s4;
			byp_s5 <= byp_s4;
		end
	end

	logic signed [RPW-1:0] rr [9];
	logic signed [OW-1:0]  sum [9];
	logic signed [DW-1:0]  sat [9];
	always_comb begin
		for (int i = 0; i < 9; i++) begin
			rr[i]  = r_s5[i] + RPW'(HALF);
			sum[i] = OW'(f_s5[i]) + OW'($signed(rr[i][F+DW+10:F]));
			if (sum[i] > MAX_O)
				sat[i] = MAX_O[DW-1:0];
			else if (sum[i] < MIN_O)
				sat[i] = MIN_O[DW-1:0];
			else
				sat[i] = sum[i][DW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++)
				out_f[i] <= byp_s5 ? f_s5[i] : sat[i];
			out_rho <= byp_s5 ? '0 : rho_s5;
			out_ux  <= byp_s5 ? '0 : ux_s5;
			out_uy  <= byp_s5 ? '0 : uy_s5;
		end
	end
endmodule
`default_nettype wire

### src/lbm_d2q9_srt_collision.sv
// D2Q9 BGK collision of one lattice cell per item, top level.
// Uses lbmc_pkg, lbmc_div and lbmc_feq.
//
// Usage:
//   s_tdata carries the nine shifted distributions of a cell, s_tuser the bypass flag
//   for solid or gas cells. m_tdata returns the nine relaxed distributions, the
//   density and both clamped velocities.
//   cfg_we with cfg_index and cfg_data writes the relaxation rate or the velocity
//   limit; write only while no item is in flight.
// Throughput: one item per cycle. Every stage moves on one common enable, so the
//   pipeline takes a new item in each cycle in which the output register is empty
//   or being taken.
// Stages from accept to m_tvalid, in order:
//   input and moment stages, the divider with one quotient bit per stage, then the
//   six stages of equilibrium and relaxation.
// Reset: clears all valid bits and loads the register defaults (rate one, limit
//   one over root three).
// Stall: while m_tvalid is high and m_tready low the whole pipeline holds and
//   s_tready is low; no item is lost or repeated.
`default_nettype none
module lbm_d2q9_srt_collision #(
	parameter int DATA_WIDTH = lbmc_pkg::DATA_WIDTH,
	parameter int FRAC_BITS  = lbmc_pkg::FRAC_BITS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// ddf_0 .. ddf_8, zero padded to bytes
	input  wire logic [((9*DATA_WIDTH+7)/8)*8-1:0]  s_tdata,
	// cell_bypass
	input  wire logic                               s_tuser,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// out_ddf_0 .. out_ddf_8, density, velocity_x, velocity_y, zero padded to bytes
	output logic [((10*DATA_WIDTH+2*FRAC_BITS+11)/8)*8-1:0] m_tdata,
	input  wire logic                               cfg_we,
	input  wire logic [lbmc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [FRAC_BITS+1:0]               cfg_data
);
	localparam int DW  = DATA_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int MW  = DW + 4;
	localparam int VW  = F + 2;
	localparam int DIV_LAT = F + 4;
	localparam logic [F+1:0] RELAX_RESET = (F+2)'(longint'(1) << F);
	localparam logic [F:0]   VLIM_RESET  =
		(F+1)'((lbmc_pkg::VLIM_RESET_Q20 * (longint'(1) << F) + (longint'(1) << 19)) >>> 20);
	localparam logic [F:0]   ONE_L = (F+1)'(longint'(1) << F);
	localparam logic signed [MW-1:0] ONE_M = MW'(longint'(1) << F);
	localparam logic signed [MW-1:0] MAX_M = MW'((longint'(1) << (DW - 1)) - 1);
	localparam logic signed [MW-1:0] MIN_M = -MAX_M - MW'(1);

	logic [F+1:0] relax_q;
	logic [F:0]   vlim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relax_q <= RELAX_RESET;
			vlim_q  <= VLIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				lbmc_pkg::CFG_RELAX_RATE:     relax_q <= cfg_data;
				lbmc_pkg::CFG_VELOCITY_LIMIT: vlim_q  <= cfg_data[F:0];
				default: ;
			endcase
		end
	end

	logic [F:0] lim;
	always_comb lim = (vlim_q > ONE_L) ? ONE_L : vlim_q;

	logic en;
	always_comb begin
		en       = !m_tvalid || m_tready;
		s_tready = en;
	end

	logic                 v_s1, v_s2;
	logic signed [DW-1:0] f_s1 [9], f_s2 [9];
	logic                 byp_s1, byp_s2;
	logic signed [DW-1:0] rho_s2;
	logic signed [MW-1:0] mx_s2, my_s2;

	logic                 v_d   [DIV_LAT];
	logic signed [DW-1:0] f_d   [DIV_LAT][9];
	logic signed [DW-1:0] rho_d [DIV_LAT];
	logic                 byp_d [DIV_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			for (int k = 0; k < DIV_LAT; k++)
				v_d[k] <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_d[0] <= v_s2;
			for (int k = 1; k < DIV_LAT; k++)
				v_d[k] <= v_d[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++)
				f_s1[i] <= s_tdata[i*DW +: DW];
			byp_s1 <= s_tuser;
		end
	end

	logic signed [MW-1:0] rsum;
	logic signed [DW-1:0] rsat;
	always_comb begin
		rsum = ONE_M;
		for (int i = 0; i < 9; i++)
			rsum = rsum + MW'(f_s1[i]);
		if (rsum > MAX_M)
			rsat = MAX_M[DW-1:0];
		else if (rsum < MIN_M)
			rsat = MIN_M[DW-1:0];
		else
			rsat = rsum[DW-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s2   <= f_s1;
			byp_s2 <= byp_s1;
			rho_s2 <= rsat;
			mx_s2  <= MW'(f_s1[1]) - MW'(f_s1[2]) + MW'(f_s1[5]) - MW'(f_s1[6])
				+ MW'(f_s1[7]) - MW'(f_s1[8]);
			my_s2  <= MW'(f_s1[3]) - MW'(f_s1[4]) + MW'(f_s1[5]) - MW'(f_s1[6])
				+ MW'(f_s1[8]) - MW'(f_s1[7]);
		end
	end

	// hold cell data beside the dividers
	always_ff @(posedge clk) begin
		if (en) begin
			f_d[0]   <= f_s2;
			rho_d[0] <= rho_s2;
			byp_d[0] <= byp_s2;
			for (int k = 1; k < DIV_LAT; k++) begin
				f_d[k]   <= f_d[k-1];
				rho_d[k] <= rho_d[k-1];
				byp_d[k] <= byp_d[k-1];
			end
		end
	end

	logic signed [VW-1:0] ux, uy;

	lbmc_div #(.DATA_WIDTH(DW), .FRAC_BITS(F)) u_div_x (
		.clk(clk), .en(en), .m(mx_s2), .rho(rho_s2), .lim(lim), .vel_s(ux)
	);

	lbmc_div #(.DATA_WIDTH(DW), .FRAC_BITS(F)) u_div_y (
		.clk(clk), .en(en), .m(my_s2), .rho(rho_s2), .lim(lim), .vel_s(uy)
	);

	logic signed [DW-1:0] out_f [9];
	logic signed [DW-1:0] out_rho;
	logic signed [VW-1:0] out_ux, out_uy;

	lbmc_feq #(.DATA_WIDTH(DW), .FRAC_BITS(F)) u_feq (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_d[DIV_LAT-1]), .f(f_d[DIV_LAT-1]), .rho(rho_d[DIV_LAT-1]),
		.ux(ux), .uy(uy), .byp(byp_d[DIV_LAT-1]), .relax(relax_q),
		.out_valid(m_tvalid), .out_f(out_f), .out_rho(out_rho),
		.out_ux(out_ux), .out_uy(out_uy)
	);

	always_comb begin
		m_tdata = '0;
		for (int i = 0; i < 9; i++)
			m_tdata[i*DW +: DW] = out_f[i];
		m_tdata[9*DW +: DW]       = out_rho;
		m_tdata[10*DW +: VW]      = out_ux;
		m_tdata[10*DW + VW +: VW] = out_uy;
	end
endmodule
`default_nettype wire

### src/lbmc_checker.sv
// Port-level checks for the collision block, with the bind that attaches them.
// Depends on lbm_d2q9_srt_collision and lbmc_pkg.
`default_nettype none
module lbmc_checker #(
	parameter int DATA_WIDTH = lbmc_pkg::DATA_WIDTH,
	parameter int FRAC_BITS  = lbmc_pkg::FRAC_BITS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	input wire logic s_tready,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [((10*DATA_WIDTH+2*FRAC_BITS+11)/8)*8-1:0] m_tdata
);
	localparam int DW = DATA_WIDTH;
	localparam int VW = FRAC_BITS + 2;
	localparam logic signed [VW-1:0] ONE_V = VW'(longint'(1) << FRAC_BITS);

	logic signed [VW-1:0] vx, vy;
	assign vx = m_tdata[10*DW +: VW];
	assign vy = m_tdata[10*DW + VW +: VW];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output item changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid |-> (s_tready == (!m_tvalid || m_tready)))
		else $error("input ready does not follow output stall");

	a_vel: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (vx <= ONE_V) && (vx >= -ONE_V) && (vy <= ONE_V) && (vy >= -ONE_V))
		else $error("velocity outside unit bound");
endmodule

bind lbm_d2q9_srt_collision lbmc_checker #(
	.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)
) u_lbmc_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

### tb/lbm_d2q9_srt_collision_test.sv
// Self-checking testbench for the D2Q9 BGK collision block lbm_d2q9_srt_collision.
// Drives cells on the input stream, predicts every result and compares it field by field.
// Depends on lbmc_pkg and the block's RTL.
`timescale 1ns / 100ps
`default_nettype none
module lbm_d2q9_srt_collision_test;

	localparam int DW = 24;
	localparam int FB = 20;
	localparam int SW = 216;
	localparam int MW = 288;
	localparam longint ONE_Q = 64'sd1 << FB;
	localparam longint W_REST = ((64'sd8 << FB) + 9) / 18;
	localparam longint W_AXIS = ((64'sd2 << FB) + 9) / 18;
	localparam longint W_DIAG = ((64'sd2 << FB) + 36) / 72;
	localparam longint DMAX = (64'sd1 << (DW - 1)) - 1;
	localparam longint DMIN = -(64'sd1 << (DW - 1));
	localparam int DRAIN = 40;

	typedef logic [8:0][DW-1:0] cell_t;
	typedef struct packed {
		logic [8:0][DW-1:0] ddf;
		logic [DW-1:0]      density;
		logic [FB+1:0]      vel_x;
		logic [FB+1:0]      vel_y;
	} collision_t;
	typedef struct {
		cell_t      ddf;
		bit         bypass;
		bit         typed;
		collision_t want;
	} cell_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [SW-1:0] s_tdata = '0;
	logic s_tuser = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [MW-1:0] m_tdata;
	logic cfg_we = 0;
	logic [lbmc_pkg::CFG_IDX_W-1:0] cfg_index = lbmc_pkg::CFG_RELAX_RATE;
	logic [FB+1:0] cfg_data = '0;

	longint relax_q = 1048576;
	longint vlim_q = lbmc_pkg::VLIM_RESET_Q20;
	collision_t pending_cells[$];
	int errors = 0;
	int cells_sent = 0;
	int cells_checked = 0;
	int bypass_sent = 0;
	int idle_pct = 0;
	int stall_pct = 0;

	lbm_d2q9_srt_collision i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	initial begin
		#10ms;
		$display("tb: failure");
		$finish;
	end

	function automatic longint mulq(longint a, longint b);
		longint bh, bl;
		bh = b >>> FB;
		bl = b - bh * ONE_Q;
		return a * bh + ((a * bl + (ONE_Q >>> 1)) >>> FB);
	endfunction

	function automatic longint sat_dw(longint x);
		return x > DMAX ? DMAX : (x < DMIN ? DMIN : x);
	endfunction

	function automatic longint clamp_speed(longint m, longint rho, longint lim);
		longint u;
		if (rho <= 0)
			return m > 0 ? lim : (m < 0 ? -lim : 0);
		u = (m * ONE_Q) / rho;
		return u > lim ? lim : (u < -lim ? -lim : u);
	endfunction

	function automatic longint equilibrium(longint rho, longint cu, longint u2, longint w);
		longint t, s;
		t = 3 * cu + ((9 * mulq(cu, cu) - 3 * u2 + 1) >>> 1);
		s = mulq(rho, t) + rho - ONE_Q;
		return mulq(w, s);
	endfunction

	function automatic collision_t collide(cell_t ddf, bit bypass);
		collision_t r;
		longint f[9];
		longint eq[9];
		longint rho, mx, my, ux, uy, u2, lim;
		for (int i = 0; i < 9; i++)
			f[i] = longint'(signed'(ddf[i]));
		r.ddf = ddf;
		r.density = '0;
		r.vel_x = '0;
		r.vel_y = '0;
		if (bypass)
			return r;
		rho = ONE_Q;
		for (int i = 0; i < 9; i++)
			rho += f[i];
		rho = sat_dw(rho);
		mx = f[1] - f[2] + f[5] - f[6] + f[7] - f[8];
		my = f[3] - f[4] + f[5] - f[6] + f[8] - f[7];
		lim = vlim_q > ONE_Q ? ONE_Q : vlim_q;
		ux = clamp_speed(mx, rho, lim);
		uy = clamp_speed(my, rho, lim);
		u2 = mulq(ux, ux) + mulq(uy, uy);
		eq[0] = equilibrium(rho, 0, u2, W_REST);
		eq[1] = equilibrium(rho, ux, u2, W_AXIS);
		eq[2] = equilibrium(rho, -ux, u2, W_AXIS);
		eq[3] = equilibrium(rho, uy, u2, W_AXIS);
		eq[4] = equilibrium(rho, -uy, u2, W_AXIS);
		eq[5] = equilibrium(rho, ux + uy, u2, W_DIAG);
		eq[6] = equilibrium(rho, -(ux + uy), u2, W_DIAG);
		eq[7] = equilibrium(rho, ux - uy, u2, W_DIAG);
		eq[8] = equilibrium(rho, uy - ux, u2, W_DIAG);
		for (int i = 0; i < 9; i++)
			r.ddf[i] = DW'(sat_dw(f[i] + mulq(relax_q, eq[i] - f[i])));
		r.density = DW'(rho);
		r.vel_x = (FB + 2)'(ux);
		r.vel_y = (FB + 2)'(uy);
		return r;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		errors++;
		$display("mismatch at cell %0d, %s: got %0d, expected %0d", cells_checked, field, got,
			want);
	endtask

	always @(posedge clk) begin
		m_tready <= arst_n && ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		collision_t got, want;
		if (m_tvalid && m_tready) begin
			got = {m_tdata[215:0], m_tdata[239:216], m_tdata[261:240], m_tdata[283:262]};
			if (pending_cells.size() == 0) begin
				report_mismatch("unexpected cell", 1, 0);
			end else begin
				want = pending_cells.pop_front();
				for (int i = 0; i < 9; i++)
					if (got.ddf[i] !== want.ddf[i])
						report_mismatch($sformatf("out_ddf_%0d", i), signed'(got.ddf[i]),
							signed'(want.ddf[i]));
				if (got.density !== want.density)
					report_mismatch("density", signed'(got.density), signed'(want.density));
				if (got.vel_x !== want.vel_x)
					report_mismatch("velocity_x", signed'(got.vel_x), signed'(want.vel_x));
				if (got.vel_y !== want.vel_y)
					report_mismatch("velocity_y", signed'(got.vel_y), signed'(want.vel_y));
			end
			cells_checked++;
		end
	end

	task automatic send_cell(cell_t ddf, bit bypass, bit typed, collision_t want);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= ddf;
		s_tuser <= bypass;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_cells.push_back(typed ? want : collide(ddf, bypass));
		cells_sent++;
		bypass_sent += bypass;
	endtask

	task automatic drain();
		s_tvalid <= 0;
		@(posedge clk);
		while (pending_cells.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(logic [lbmc_pkg::CFG_IDX_W-1:0] idx, longint value);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= (FB + 2)'(value);
		@(posedge clk);
		cfg_we <= 0;
		if (idx == lbmc_pkg::CFG_RELAX_RATE)
			relax_q = value & ((64'sd1 << (FB + 2)) - 1);
		else
			vlim_q = value & ((64'sd1 << (FB + 1)) - 1);
		@(posedge clk);
	endtask

	function automatic logic [DW-1:0] rand_ddf(bit wide);
		if (wide)
			return DW'($urandom);
		return DW'(int'($urandom_range(0, 131072)) - 65536);
	endfunction

	task automatic random_cells(int count, int pressure_at);
		cell_t ddf;
		collision_t none;
		bit wide;
		none = '0;
		for (int n = 0; n < count; n++) begin
			if (n == pressure_at) begin
				s_tvalid <= 0;
				@(posedge clk);
				while (pending_cells.size() != 0)
					@(posedge clk);
			end
			wide = $urandom_range(0, 99) < 20;
			for (int i = 0; i < 9; i++)
				ddf[i] = rand_ddf(wide);
			send_cell(ddf, $urandom_range(0, 9) == 0, 0, none);
		end
	endtask

	initial begin
		cell_row_t rows[$];
		cell_row_t row;
		collision_t zero_res;
		zero_res = '0;

		row.typed = 1;
		row.bypass = 1;
		row.ddf = {9{24'h7fffff}};
		row.want = zero_res;
		row.want.ddf = row.ddf;
		rows.push_back(row);
		row.ddf = {9{24'h800000}};
		row.want.ddf = row.ddf;
		rows.push_back(row);
		row.bypass = 0;
		row.ddf = '0;
		row.want = zero_res;
		row.want.density = DW'(ONE_Q);
		rows.push_back(row);
		row.typed = 0;
		row.want = zero_res;
		row.ddf = {9{24'h7fffff}};
		rows.push_back(row);
		row.ddf = {9{24'h800000}};
		rows.push_back(row);
		row.ddf = '0;
		row.ddf[0] = DW'(-2 * ONE_Q);
		row.ddf[1] = DW'(ONE_Q);
		rows.push_back(row);
		row.ddf[1] = '0;
		row.ddf[2] = DW'(ONE_Q);
		rows.push_back(row);
		row.ddf[2] = '0;
		row.ddf[3] = DW'(ONE_Q);
		rows.push_back(row);
		row.ddf[3] = '0;
		row.ddf[8] = DW'(ONE_Q);
		rows.push_back(row);
		row.ddf = '0;
		row.ddf[1] = DW'(ONE_Q / 2);
		row.ddf[5] = DW'(ONE_Q / 4);
		rows.push_back(row);
		row.ddf = '0;
		row.ddf[2] = 24'h7fffff;
		row.ddf[6] = 24'h7fffff;
		rows.push_back(row);
		row.ddf = '0;
		row.ddf[4] = DW'(ONE_Q / 8);
		row.ddf[7] = DW'(-ONE_Q / 16);
		rows.push_back(row);
		row.ddf = {24'h555555, 24'haaaaaa, 24'h555555, 24'haaaaaa, 24'h555555,
			24'haaaaaa, 24'h555555, 24'haaaaaa, 24'h555555};
		rows.push_back(row);
		row.ddf = ~row.ddf;
		rows.push_back(row);
		row.bypass = 1;
		row.ddf = {9{24'h123456}};
		rows.push_back(row);

		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (rows[k])
			send_cell(rows[k].ddf, rows[k].bypass, rows[k].typed, rows[k].want);
		random_cells(100, -1);
		drain();

		write_reg(lbmc_pkg::CFG_RELAX_RATE, 0);
		write_reg(lbmc_pkg::CFG_VELOCITY_LIMIT, 0);
		idle_pct = 85;
		foreach (rows[k])
			send_cell(rows[k].ddf, rows[k].bypass, 0, zero_res);
		random_cells(90, 50);
		drain();

		write_reg(lbmc_pkg::CFG_RELAX_RATE, 2097152);
		write_reg(lbmc_pkg::CFG_VELOCITY_LIMIT, 1048576);
		idle_pct = 0;
		stall_pct = 85;
		foreach (rows[k])
			send_cell(rows[k].ddf, rows[k].bypass, 0, zero_res);
		random_cells(90, -1);
		drain();

		write_reg(lbmc_pkg::CFG_RELAX_RATE, 4194303);
		write_reg(lbmc_pkg::CFG_VELOCITY_LIMIT, 2097151);
		idle_pct = 26;
		stall_pct = 26;
		foreach (rows[k])
			send_cell(rows[k].ddf, rows[k].bypass, 0, zero_res);
		random_cells(90, -1);
		drain();

		write_reg(lbmc_pkg::CFG_RELAX_RATE, $urandom_range(0, 2097152));
		write_reg(lbmc_pkg::CFG_VELOCITY_LIMIT, $urandom_range(0, 1048576));
		idle_pct = 0;
		stall_pct = 0;
		random_cells(100, -1);
		drain();

		$display("covered %0d cells (%0d bypassed), %0d checked, five register settings",
			cells_sent, bypass_sent, cells_checked);
		$display("settings span zero and full relaxation, zero and unit limits, over-range bits");
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire
